// File: design/pfa_pkg.sv
// shared types for the polygon footprint area pipeline
`default_nettype none

package pfa_pkg;

    // per-vertex control flags that travel with each item
    typedef struct packed {
        logic first_vertex;
        logic ring_end;
        logic record_end;
    } flags_t;

    // record status handed from the totals stage to the result stage
    typedef struct packed {
        logic ref_negative;
        logic nonzero;
        logic overflow;
    } rec_status_t;

endpackage

`default_nettype wire

// File: design/pfa_vertex.sv
// input register and ring start/previous vertex tracking
`default_nettype none

module pfa_vertex #(
    parameter int COORD_BITS = 24
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  signed [COORD_BITS-1:0] in_x,
    input  wire  signed [COORD_BITS-1:0] in_y,
    input  wire                          in_ring_end,
    input  wire                          in_record_end,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic signed [COORD_BITS-1:0] out_px,
    output logic signed [COORD_BITS-1:0] out_py,
    output logic signed [COORD_BITS-1:0] out_fx,
    output logic signed [COORD_BITS-1:0] out_fy,
    output pfa_pkg::flags_t              out_flags
);

    logic                         vld_reg, vld_next;
    logic                         start_pending_reg, start_pending_next;
    logic signed [COORD_BITS-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic signed [COORD_BITS-1:0] x_reg, y_reg, px_reg, py_reg, fx_reg, fy_reg;
    pfa_pkg::flags_t              flags_reg, flags_next;
    logic signed [COORD_BITS-1:0] fx_sel, fy_sel;
    logic                         accept;

    assign in_ready = !vld_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // first vertex of a ring is the one that arrives while a start is pending
    always_comb begin
        fx_sel = start_pending_reg ? in_x : first_x_reg;
        fy_sel = start_pending_reg ? in_y : first_y_reg;
        flags_next.first_vertex = start_pending_reg;
        flags_next.ring_end     = in_ring_end || in_record_end;
        flags_next.record_end   = in_record_end;
    end

    // control next state
    always_comb begin
        vld_next           = vld_reg;
        start_pending_next = start_pending_reg;
        if (accept) begin
            vld_next           = 1'b1;
            start_pending_next = flags_next.ring_end;
        end else if (out_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg           <= 1'b0;
            start_pending_reg <= 1'b1;
        end else begin
            vld_reg           <= vld_next;
            start_pending_reg <= start_pending_next;
        end
    end

    // vertex history and stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            first_x_reg <= fx_sel;
            first_y_reg <= fy_sel;
            prev_x_reg  <= in_x;
            prev_y_reg  <= in_y;
            x_reg       <= in_x;
            y_reg       <= in_y;
            px_reg      <= prev_x_reg;
            py_reg      <= prev_y_reg;
            fx_reg      <= fx_sel;
            fy_reg      <= fy_sel;
            flags_reg   <= flags_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_px    = px_reg;
    assign out_py    = py_reg;
    assign out_fx    = fx_reg;
    assign out_fy    = fy_reg;
    assign out_flags = flags_reg;

endmodule

`default_nettype wire

// File: design/pfa_edge.sv
// cross products and shoelace edge terms, two pipeline stages
`default_nettype none

module pfa_edge #(
    parameter int COORD_BITS = 24
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire  signed [COORD_BITS-1:0]   in_x,
    input  wire  signed [COORD_BITS-1:0]   in_y,
    input  wire  signed [COORD_BITS-1:0]   in_px,
    input  wire  signed [COORD_BITS-1:0]   in_py,
    input  wire  signed [COORD_BITS-1:0]   in_fx,
    input  wire  signed [COORD_BITS-1:0]   in_fy,
    input  pfa_pkg::flags_t                in_flags,
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic signed [2*COORD_BITS:0]   out_open,
    output logic signed [2*COORD_BITS:0]   out_close,
    output pfa_pkg::flags_t                out_flags
);

    localparam int P = 2 * COORD_BITS;
    localparam int T = P + 1;

    logic                mul_v_reg, mul_v_next;
    logic                trm_v_reg, trm_v_next;
    logic                mul_ready, trm_ready;
    logic signed [P-1:0] oa_reg, ob_reg, ca_reg, cb_reg;
    pfa_pkg::flags_t     mul_flags_reg, trm_flags_reg;
    logic signed [T-1:0] open_reg, close_reg;
    logic signed [T-1:0] diff_open, diff_close;

    assign trm_ready = !trm_v_reg || out_ready;
    assign mul_ready = !mul_v_reg || trm_ready;
    assign in_ready  = mul_ready;

    // stage valids
    always_comb begin
        mul_v_next = mul_v_reg;
        trm_v_next = trm_v_reg;
        if (mul_ready) begin
            mul_v_next = in_valid;
        end
        if (trm_ready) begin
            trm_v_next = mul_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_v_reg <= 1'b0;
            trm_v_reg <= 1'b0;
        end else begin
            mul_v_reg <= mul_v_next;
            trm_v_reg <= trm_v_next;
        end
    end

    // four independent products: prev-to-current and current-to-first edges
    always_ff @(posedge aclk) begin
        if (mul_ready && in_valid) begin
            oa_reg        <= P'(in_px) * P'(in_y);
            ob_reg        <= P'(in_x) * P'(in_py);
            ca_reg        <= P'(in_x) * P'(in_fy);
            cb_reg        <= P'(in_fx) * P'(in_y);
            mul_flags_reg <= in_flags;
        end
    end

    // edge terms, zero where the edge does not exist
    always_comb begin
        diff_open  = {oa_reg[P-1], oa_reg} - {ob_reg[P-1], ob_reg};
        diff_close = {ca_reg[P-1], ca_reg} - {cb_reg[P-1], cb_reg};
    end

    always_ff @(posedge aclk) begin
        if (trm_ready && mul_v_reg) begin
            open_reg      <= mul_flags_reg.first_vertex ? '0 : diff_open;
            close_reg     <= mul_flags_reg.ring_end ? diff_close : '0;
            trm_flags_reg <= mul_flags_reg;
        end
    end

    assign out_valid = trm_v_reg;
    assign out_open  = open_reg;
    assign out_close = close_reg;
    assign out_flags = trm_flags_reg;

endmodule

`default_nettype wire

// File: design/pfa_ring.sv
// saturating ring area accumulator
`default_nettype none

module pfa_ring #(
    parameter int COORD_BITS = 24,
    parameter int AREA_BITS  = 56
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire  signed [2*COORD_BITS:0]   in_open,
    input  wire  signed [2*COORD_BITS:0]   in_close,
    input  pfa_pkg::flags_t                in_flags,
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic signed [AREA_BITS-5:0]    out_ring,
    output logic                           out_ovf,
    output pfa_pkg::flags_t                out_flags
);

    localparam int T = 2 * COORD_BITS + 1;
    localparam int R = AREA_BITS - 4;
    localparam int W = ((T > R) ? T : R) + 1;
    localparam logic signed [W-1:0] RMAX = {{(W-R+1){1'b0}}, {(R-1){1'b1}}};
    localparam logic signed [W-1:0] RMIN = ~RMAX;

    logic                vld_reg, vld_next;
    logic signed [R-1:0] ring_sum_reg, ring_sum_next;
    logic signed [R-1:0] ring_out_reg;
    logic                ovf_reg;
    pfa_pkg::flags_t     flags_reg;
    logic signed [W-1:0] sum1, sum2;
    logic signed [R-1:0] r1, r2;
    logic                o1, o2;
    logic                accept;

    assign in_ready = !vld_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // open edge first, then the closing edge, each clamped to the ring range
    always_comb begin
        sum1 = {{(W-R){ring_sum_reg[R-1]}}, ring_sum_reg} + {{(W-T){in_open[T-1]}}, in_open};
        o1   = (sum1 > RMAX) || (sum1 < RMIN);
        r1   = (sum1 > RMAX) ? RMAX[R-1:0] : ((sum1 < RMIN) ? RMIN[R-1:0] : sum1[R-1:0]);
        sum2 = {{(W-R){r1[R-1]}}, r1} + {{(W-T){in_close[T-1]}}, in_close};
        o2   = (sum2 > RMAX) || (sum2 < RMIN);
        r2   = (sum2 > RMAX) ? RMAX[R-1:0] : ((sum2 < RMIN) ? RMIN[R-1:0] : sum2[R-1:0]);
    end

    // accumulator and stage valid
    always_comb begin
        vld_next      = vld_reg;
        ring_sum_next = ring_sum_reg;
        if (accept) begin
            vld_next      = 1'b1;
            ring_sum_next = in_flags.ring_end ? '0 : r2;
        end else if (out_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= 1'b0;
            ring_sum_reg <= '0;
        end else begin
            vld_reg      <= vld_next;
            ring_sum_reg <= ring_sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ring_out_reg <= r2;
            ovf_reg      <= o1 || o2;
            flags_reg    <= in_flags;
        end
    end

    assign out_valid = vld_reg;
    assign out_ring  = ring_out_reg;
    assign out_ovf   = ovf_reg;
    assign out_flags = flags_reg;

endmodule

`default_nettype wire

// File: design/pfa_record.sv
// per-record totals, largest ring and reference sign
`default_nettype none

module pfa_record #(
    parameter int AREA_BITS = 56
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  signed [AREA_BITS-5:0]  in_ring,
    input  wire                          in_ovf,
    input  pfa_pkg::flags_t              in_flags,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [AREA_BITS-1:0]         out_pos,
    output logic [AREA_BITS-1:0]         out_neg,
    output pfa_pkg::rec_status_t         out_status
);

    localparam int A = AREA_BITS;
    localparam int R = AREA_BITS - 4;

    logic                 vld_reg, vld_next;
    logic [A-1:0]         pos_reg, pos_next, neg_reg, neg_next;
    logic [R-1:0]         largest_reg, largest_next;
    logic                 ref_neg_reg, ref_neg_next;
    logic                 ovf_seen_reg, ovf_seen_next;
    logic [A-1:0]         snap_pos_reg, snap_neg_reg;
    pfa_pkg::rec_status_t snap_status_reg, snap_status_next;
    logic                 ring_neg;
    logic [R-1:0]         mag;
    logic [A:0]           pos_sum, neg_sum;
    logic [A-1:0]         pos_upd, neg_upd;
    logic                 accept;

    assign in_ready = !vld_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // ring magnitude and saturating total updates
    always_comb begin
        ring_neg = in_ring[R-1];
        mag      = ring_neg ? ('0 - $unsigned(in_ring)) : $unsigned(in_ring);
        pos_sum  = {1'b0, pos_reg} + {{(A-R+1){1'b0}}, mag};
        neg_sum  = {1'b0, neg_reg} + {{(A-R+1){1'b0}}, mag};
        pos_upd  = pos_sum[A] ? '1 : pos_sum[A-1:0];
        neg_upd  = neg_sum[A] ? '1 : neg_sum[A-1:0];
    end

    // record state next values
    always_comb begin
        pos_next      = pos_reg;
        neg_next      = neg_reg;
        largest_next  = largest_reg;
        ref_neg_next  = ref_neg_reg;
        ovf_seen_next = ovf_seen_reg || in_ovf;
        if (in_flags.ring_end) begin
            if (mag > largest_reg) begin
                largest_next = mag;
                ref_neg_next = ring_neg;
            end
            if (ring_neg) begin
                neg_next      = neg_upd;
                ovf_seen_next = ovf_seen_reg || in_ovf || neg_sum[A];
            end else begin
                pos_next      = pos_upd;
                ovf_seen_next = ovf_seen_reg || in_ovf || pos_sum[A];
            end
        end
        snap_status_next.ref_negative = ref_neg_next;
        snap_status_next.nonzero      = (largest_next != '0);
        snap_status_next.overflow     = ovf_seen_next;
        vld_next = vld_reg;
        if (accept && in_flags.record_end) begin
            vld_next = 1'b1;
        end else if (out_ready) begin
            vld_next = 1'b0;
        end
    end

    // record state, cleared at record end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= 1'b0;
            pos_reg      <= '0;
            neg_reg      <= '0;
            largest_reg  <= '0;
            ref_neg_reg  <= 1'b0;
            ovf_seen_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
            if (accept) begin
                if (in_flags.record_end) begin
                    pos_reg      <= '0;
                    neg_reg      <= '0;
                    largest_reg  <= '0;
                    ref_neg_reg  <= 1'b0;
                    ovf_seen_reg <= 1'b0;
                end else begin
                    pos_reg      <= pos_next;
                    neg_reg      <= neg_next;
                    largest_reg  <= largest_next;
                    ref_neg_reg  <= ref_neg_next;
                    ovf_seen_reg <= ovf_seen_next;
                end
            end
        end
    end

    // snapshot of the finished record
    always_ff @(posedge aclk) begin
        if (accept && in_flags.record_end) begin
            snap_pos_reg    <= pos_next;
            snap_neg_reg    <= neg_next;
            snap_status_reg <= snap_status_next;
        end
    end

    assign out_valid  = vld_reg;
    assign out_pos    = snap_pos_reg;
    assign out_neg    = snap_neg_reg;
    assign out_status = snap_status_reg;

endmodule

`default_nettype wire

// File: design/pfa_result.sv
// footprint selection and output register
`default_nettype none

module pfa_result #(
    parameter int AREA_BITS = 56
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire  [AREA_BITS-1:0]  in_pos,
    input  wire  [AREA_BITS-1:0]  in_neg,
    input  pfa_pkg::rec_status_t  in_status,
    output logic                  out_valid,
    input  wire                   out_ready,
    output logic [AREA_BITS-1:0]  out_footprint_twice,
    output logic                  out_footprint_valid,
    output logic                  out_saturated
);

    localparam int A = AREA_BITS;

    logic         vld_reg, vld_next;
    logic [A-1:0] fp_reg, fp_next;
    logic         fp_valid_reg, sat_reg, sat_next;
    logic [A-1:0] same, opp, diff;
    logic [A:0]   both;
    logic         same_gt;
    logic         accept;

    assign in_ready = !vld_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // reference-sign rings add, others subtract; fall back to the sum of both
    always_comb begin
        same    = in_status.ref_negative ? in_neg : in_pos;
        opp     = in_status.ref_negative ? in_pos : in_neg;
        diff    = same - opp;
        same_gt = same > opp;
        both    = {1'b0, in_pos} + {1'b0, in_neg};
        fp_next  = '0;
        sat_next = in_status.overflow;
        if (in_status.nonzero) begin
            if (same_gt) begin
                fp_next = diff;
            end else begin
                fp_next  = both[A] ? '1 : both[A-1:0];
                sat_next = in_status.overflow || both[A];
            end
        end
        vld_next = vld_reg;
        if (accept) begin
            vld_next = 1'b1;
        end else if (out_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            fp_reg       <= fp_next;
            fp_valid_reg <= in_status.nonzero;
            sat_reg      <= sat_next;
        end
    end

    assign out_valid           = vld_reg;
    assign out_footprint_twice = fp_reg;
    assign out_footprint_valid = fp_valid_reg;
    assign out_saturated       = sat_reg;

endmodule

`default_nettype wire

// File: design/polygon_footprint_area.sv
// top level: doubled polygon footprint area by the shoelace rule with holes
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    vertex_x, vertex_y, ring_end, record_end
//  m_       out        m_valid / m_ready    footprint_twice, footprint_valid, saturated
//
// one vertex item is taken every cycle while s_ready is high; a record's result passes
// through the vertex, product, edge-term, ring, totals and result registers to m_. the rate is set by the ring
// accumulator, which applies both edge terms of a vertex in a single combinational pass.
// reset is synchronous and active low and clears the pipeline and all record state.
// each stage has its own skid-free register; a stalled m_ side fills the stages
// in turn before s_ready falls.
`default_nettype none

module polygon_footprint_area #(
    parameter int COORD_BITS = 24,
    parameter int AREA_BITS  = 56
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  signed [COORD_BITS-1:0] s_vertex_x,
    input  wire  signed [COORD_BITS-1:0] s_vertex_y,
    input  wire                          s_ring_end,
    input  wire                          s_record_end,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [AREA_BITS-1:0]         m_footprint_twice,
    output logic                         m_footprint_valid,
    output logic                         m_saturated
);

    localparam int T = 2 * COORD_BITS + 1;
    localparam int R = AREA_BITS - 4;

    logic                         vtx_v, vtx_rdy;
    logic signed [COORD_BITS-1:0] vtx_x, vtx_y, vtx_px, vtx_py, vtx_fx, vtx_fy;
    pfa_pkg::flags_t              vtx_flags;
    logic                         edg_v, edg_rdy;
    logic signed [T-1:0]          edg_open, edg_close;
    pfa_pkg::flags_t              edg_flags;
    logic                         rng_v, rng_rdy;
    logic signed [R-1:0]          rng_val;
    logic                         rng_ovf;
    pfa_pkg::flags_t              rng_flags;
    logic                         rec_v, rec_rdy;
    logic [AREA_BITS-1:0]         rec_pos, rec_neg;
    pfa_pkg::rec_status_t         rec_status;

    // vertex input stage
    pfa_vertex #(.COORD_BITS(COORD_BITS)) u_vertex (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_x          (s_vertex_x),
        .in_y          (s_vertex_y),
        .in_ring_end   (s_ring_end),
        .in_record_end (s_record_end),
        .out_valid     (vtx_v),
        .out_ready     (vtx_rdy),
        .out_x         (vtx_x),
        .out_y         (vtx_y),
        .out_px        (vtx_px),
        .out_py        (vtx_py),
        .out_fx        (vtx_fx),
        .out_fy        (vtx_fy),
        .out_flags     (vtx_flags)
    );

    // edge terms
    pfa_edge #(.COORD_BITS(COORD_BITS)) u_edge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vtx_v),
        .in_ready  (vtx_rdy),
        .in_x      (vtx_x),
        .in_y      (vtx_y),
        .in_px     (vtx_px),
        .in_py     (vtx_py),
        .in_fx     (vtx_fx),
        .in_fy     (vtx_fy),
        .in_flags  (vtx_flags),
        .out_valid (edg_v),
        .out_ready (edg_rdy),
        .out_open  (edg_open),
        .out_close (edg_close),
        .out_flags (edg_flags)
    );

    // ring accumulation
    pfa_ring #(.COORD_BITS(COORD_BITS), .AREA_BITS(AREA_BITS)) u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (edg_v),
        .in_ready  (edg_rdy),
        .in_open   (edg_open),
        .in_close  (edg_close),
        .in_flags  (edg_flags),
        .out_valid (rng_v),
        .out_ready (rng_rdy),
        .out_ring  (rng_val),
        .out_ovf   (rng_ovf),
        .out_flags (rng_flags)
    );

    // record totals
    pfa_record #(.AREA_BITS(AREA_BITS)) u_record (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (rng_v),
        .in_ready   (rng_rdy),
        .in_ring    (rng_val),
        .in_ovf     (rng_ovf),
        .in_flags   (rng_flags),
        .out_valid  (rec_v),
        .out_ready  (rec_rdy),
        .out_pos    (rec_pos),
        .out_neg    (rec_neg),
        .out_status (rec_status)
    );

    // result selection and output register
    pfa_result #(.AREA_BITS(AREA_BITS)) u_result (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .in_valid            (rec_v),
        .in_ready            (rec_rdy),
        .in_pos              (rec_pos),
        .in_neg              (rec_neg),
        .in_status           (rec_status),
        .out_valid           (m_valid),
        .out_ready           (m_ready),
        .out_footprint_twice (m_footprint_twice),
        .out_footprint_valid (m_footprint_valid),
        .out_saturated       (m_saturated)
    );

    // input backpressure only when the first stage holds an item
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> vtx_v)
        else $error("input stalled with empty vertex stage");

    // a record end always closes its ring on the way through the pipeline
    a_rec_closes_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (rng_v && rng_flags.record_end) |-> rng_flags.ring_end)
        else $error("record end without ring end");

    // a record end accepted by the totals stage produces a snapshot next cycle
    a_rec_snapshot: assert property (@(posedge aclk) disable iff (!aresetn)
        (rng_v && rng_rdy && rng_flags.record_end) |=> rec_v)
        else $error("record end lost before result stage");

    // a rejected record carries a zero footprint
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_footprint_valid) |-> (m_footprint_twice == '0))
        else $error("rejected record with nonzero footprint");

endmodule

`default_nettype wire

// File: bench/tb_polygon_footprint_area.sv
`timescale 1ns / 100ps
// testbench for polygon_footprint_area: vertex records in, predicted footprints checked out

module tb_polygon_footprint_area;

    localparam int COORD_W = 24;
    localparam int AREA_W  = 56;
    localparam int RING_W  = AREA_W - 4;

    localparam longint          RING_HI  = (longint'(1) <<< (RING_W - 1)) - 1;
    localparam longint          RING_LO  = -RING_HI - 1;
    localparam longint unsigned AREA_TOP = (64'd1 << AREA_W) - 1;

    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    localparam int unsigned LONG_HOLD  = 300;
    localparam int unsigned IDLE_LIMIT = 2000;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        bit                        ring_end;
        bit                        record_end;
        int unsigned               gap;
    } vertex_item_t;

    typedef struct {
        logic [AREA_W-1:0] twice;
        bit                valid;
        bit                sat;
    } footprint_t;

    vertex_item_t vertex_q[$];
    footprint_t   footprint_due[$];

    logic                      aclk;
    logic                      aresetn    = 1'b0;
    logic                      s_valid    = 1'b0;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_vertex_x = '0;
    logic signed [COORD_W-1:0] s_vertex_y = '0;
    logic                      s_ring_end   = 1'b0;
    logic                      s_record_end = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [AREA_W-1:0]         m_footprint_twice;
    logic                      m_footprint_valid;
    logic                      m_saturated;

    int          errors       = 0;
    int          records_made = 0;
    int          hold_after   = 0;
    int          results_done = 0;
    int unsigned gap_left     = 0;
    int unsigned rx_wait      = 0;
    int unsigned idle_cycles  = 0;
    bit          calm         = 0;

    // predictor state for the open ring and record
    logic signed [COORD_W-1:0] ring_x0, ring_y0, last_x, last_y;
    bit                        opening_ring;
    longint                    ring_area;
    longint unsigned           pos_sum, neg_sum, peak_mag;
    bit                        peak_negative;
    bit                        sat_seen;

    polygon_footprint_area #(
        .COORD_BITS(COORD_W),
        .AREA_BITS (AREA_W)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_vertex_x       (s_vertex_x),
        .s_vertex_y       (s_vertex_y),
        .s_ring_end       (s_ring_end),
        .s_record_end     (s_record_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_footprint_twice(m_footprint_twice),
        .m_footprint_valid(m_footprint_valid),
        .m_saturated      (m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic clear_record();
        ring_x0 = '0; ring_y0 = '0; last_x = '0; last_y = '0;
        opening_ring  = 1;
        ring_area     = 0;
        pos_sum       = 0;
        neg_sum       = 0;
        peak_mag      = 0;
        peak_negative = 0;
        sat_seen      = 0;
    endtask

    // one shoelace edge term into the ring sum, clamped to the ring width
    task automatic add_edge_term(input longint ax, input longint ay,
                                 input longint bx, input longint by);
        longint term;
        term = ax * by - bx * ay;
        if (term > RING_HI - ring_area) begin
            ring_area = RING_HI;
            sat_seen  = 1;
        end else if (term < RING_LO - ring_area) begin
            ring_area = RING_LO;
            sat_seen  = 1;
        end else begin
            ring_area += term;
        end
    endtask

    function automatic longint unsigned sat_sum(input longint unsigned a,
                                                input longint unsigned b,
                                                output bit hit);
        hit = (b > AREA_TOP - a);
        return hit ? AREA_TOP : a + b;
    endfunction

    // advance the predictor by one accepted vertex
    task automatic take_vertex(input logic signed [COORD_W-1:0] vx,
                               input logic signed [COORD_W-1:0] vy,
                               input bit rg_flag, input bit rec_flag);
        longint unsigned mag, same, opp, fp;
        bit              hit, sat;
        footprint_t      res;
        if (opening_ring) begin
            ring_x0      = vx;
            ring_y0      = vy;
            opening_ring = 0;
        end else begin
            add_edge_term(last_x, last_y, vx, vy);
        end
        last_x = vx;
        last_y = vy;

        // ring closes: closing edge, then fold its magnitude into the totals
        if (rg_flag || rec_flag) begin
            add_edge_term(vx, vy, ring_x0, ring_y0);
            mag = (ring_area < 0) ? -ring_area : ring_area;
            if (mag > peak_mag) begin
                peak_mag      = mag;
                peak_negative = ring_area < 0;
            end
            if (ring_area < 0)
                neg_sum = sat_sum(neg_sum, mag, hit);
            else
                pos_sum = sat_sum(pos_sum, mag, hit);
            sat_seen     |= hit;
            ring_area    = 0;
            opening_ring = 1;
        end

        // record closes: reference-sign rings add, the rest subtract
        if (rec_flag) begin
            sat       = sat_seen;
            res.valid = peak_mag != 0;
            same      = peak_negative ? neg_sum : pos_sum;
            opp       = peak_negative ? pos_sum : neg_sum;
            fp        = 0;
            if (res.valid) begin
                if (same > opp) begin
                    fp = same - opp;
                end else begin
                    fp  = sat_sum(pos_sum, neg_sum, hit);
                    sat |= hit;
                end
            end
            res.twice = fp[AREA_W-1:0];
            res.sat   = sat;
            footprint_due.insert(footprint_due.size(), res);
            clear_record();
        end
    endtask

    task automatic push_vertex(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y,
                               input bit rg, input bit rec);
        vertex_item_t v;
        v.x          = x;
        v.y          = y;
        v.ring_end   = rg;
        v.record_end = rec;
        v.gap        = calm ? 0 : $urandom_range(0, 14);
        vertex_q.insert(vertex_q.size(), v);
        if (rec)
            records_made++;
    endtask

    // full-range square walked several times in one ring
    task automatic push_winding(input int loops, input bit clockwise, input bit closes_record);
        logic signed [COORD_W-1:0] cx [4];
        logic signed [COORD_W-1:0] cy [4];
        int                        k, n, idx;
        cx = '{C_MIN, C_MAX, C_MAX, C_MIN};
        cy = '{C_MIN, C_MIN, C_MAX, C_MAX};
        n  = 4 * loops;
        for (k = 0; k < n; k++) begin
            idx = clockwise ? 3 - (k % 4) : k % 4;
            push_vertex(cx[idx], cy[idx], k == n - 1, closes_record && (k == n - 1));
        end
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord(input int mode);
        case (mode)
            0: return COORD_W'($urandom);
            1: return COORD_W'(int'($urandom_range(0, 2000)) - 1000);
            default: begin
                case ($urandom_range(0, 4))
                    0: return C_MIN;
                    1: return C_MAX;
                    2: return '0;
                    3: return '1;
                    default: return COORD_W'(1);
                endcase
            end
        endcase
    endfunction

    // one record of up to four rings: mostly polygons, some short or winding rings
    task automatic push_random_record();
        int rings, r, n, k, kind, mode;
        bit last_ring, noisy, rg;
        rings = $urandom_range(1, 4);
        noisy = ($urandom_range(0, 9) == 0);
        calm  = ($urandom_range(0, 4) == 0);
        for (r = 0; r < rings; r++) begin
            last_ring = (r == rings - 1);
            kind      = $urandom_range(0, 99);
            if (kind < 8) begin
                push_winding($urandom_range(1, 5), $urandom_range(0, 1) != 0, last_ring);
            end else begin
                n    = (kind < 16) ? $urandom_range(1, 2) : $urandom_range(3, 8);
                mode = $urandom_range(0, 2);
                for (k = 0; k < n; k++) begin
                    if (k == n - 1)
                        rg = last_ring ? ($urandom_range(0, 1) != 0) : 1'b1;
                    else
                        rg = noisy && ($urandom_range(0, 5) == 0);
                    push_vertex(pick_coord(mode), pick_coord(mode), rg, last_ring && (k == n - 1));
                end
            end
        end
    endtask

    // sender: offers queued items, idles between them as each item asks
    always @(posedge aclk) begin : vertex_driver
        vertex_item_t v;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
            clear_record();
        end else begin
            if (s_valid && s_ready)
                take_vertex(s_vertex_x, s_vertex_y, s_ring_end, s_record_end);
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (vertex_q.size() != 0) begin
                    v = vertex_q.pop_front();
                    s_valid      <= 1'b1;
                    s_vertex_x   <= v.x;
                    s_vertex_y   <= v.y;
                    s_ring_end   <= v.ring_end;
                    s_record_end <= v.record_end;
                    gap_left     <= v.gap;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each footprint against the oldest prediction, then may stall a while
    always @(posedge aclk) begin : footprint_monitor
        footprint_t  want;
        int unsigned stall;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (m_valid && m_ready) begin
            results_done <= results_done + 1;
            if (footprint_due.size() == 0) begin
                $error("footprint with no record pending: footprint_twice %0d",
                       m_footprint_twice);
                errors++;
            end else begin
                want = footprint_due.pop_front();
                if (m_footprint_twice !== want.twice) begin
                    $error("footprint_twice: expected %0d, got %0d", want.twice, m_footprint_twice);
                    errors++;
                end
                if (m_footprint_valid !== want.valid) begin
                    $error("footprint_valid: expected %0d, got %0d", want.valid, m_footprint_valid);
                    errors++;
                end
                if (m_saturated !== want.sat) begin
                    $error("saturated: expected %0d, got %0d", want.sat, m_saturated);
                    errors++;
                end
            end
            if (results_done + 1 == hold_after)
                stall = LONG_HOLD;
            else if (((results_done >> 4) % 3) == 1)
                stall = 0;
            else
                stall = $urandom_range(0, 14);
            rx_wait <= stall;
            m_ready <= (stall == 0);
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
            m_ready <= (rx_wait == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int r;

        // short rings only: one vertex, then two vertices closed by record end alone
        push_vertex(5, 7, 1, 0);
        push_vertex(C_MIN, C_MAX, 0, 0);
        push_vertex(C_MAX, C_MIN, 0, 1);

        // full-range outer triangle with a small clockwise hole
        push_vertex(C_MIN, C_MIN, 0, 0);
        push_vertex(C_MAX, C_MIN, 0, 0);
        push_vertex(0, C_MAX, 1, 0);
        push_vertex(0, 0, 0, 0);
        push_vertex(0, 100, 0, 0);
        push_vertex(100, 0, 1, 1);

        // equal and opposite rings: falls back to the sum, first ring is the reference
        push_vertex(0, 0, 0, 0);
        push_vertex(0, 50, 0, 0);
        push_vertex(50, 0, 1, 0);
        push_vertex(0, 0, 0, 0);
        push_vertex(50, 0, 0, 0);
        push_vertex(0, 50, 0, 1);

        // ring sum driven past its width
        push_winding(5, 0, 1);

        repeat (12) push_random_record();

        // burst of one-vertex records while the receiver holds off
        calm       = 1;
        hold_after = records_made;
        for (r = 0; r < 40; r++)
            push_vertex(pick_coord(0), pick_coord(0), $urandom_range(0, 1) != 0, 1);

        // equal and opposite winding rings whose fallback sum saturates
        calm = 1;
        for (r = 0; r < 17; r++)
            push_winding(4, 0, 0);
        for (r = 0; r < 17; r++)
            push_winding(4, 1, r == 16);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (vertex_q.size() != 0 || s_valid)
            @(posedge aclk);
        while (footprint_due.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
